FILE: hdl/izc_pkg.sv
// izc_pkg: types, constants and arithmetic helpers of the impedance-to-component unit
// no dependencies; imported by every module under hdl but izc_fifo

package izc_pkg;

    typedef struct packed {
        logic signed [39:0] z_re;
        logic signed [39:0] z_im;
        logic [19:0]        test_freq;
    } t_in_item;

    typedef struct packed {
        logic               is_inductive;
        logic               is_parallel;
        logic signed [39:0] model_re;
        logic signed [39:0] model_im;
        logic [62:0]        reactive_value;
        logic signed [47:0] quality;
        logic               math_error;
    } t_out_item;

    // classified word handed from front to back
    typedef struct packed {
        logic signed [39:0] z_re;
        logic signed [39:0] z_im;
        logic [19:0]        freq;
        logic               comp;
        logic signed [40:0] ar;
        logic signed [40:0] ai;
        logic signed [40:0] dr;
        logic signed [40:0] di;
    } t_task;

    typedef struct packed {
        logic        start;
        logic [95:0] a_mag;
        logic [63:0] b_mag;
        logic        neg;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic signed [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [83:0]  den;
        logic [6:0]   qbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic        ovf;
    } t_div_rsp;

    typedef struct packed {
        logic signed [39:0] val;
        logic               err;
    } t_sat40;

    typedef enum logic [2:0] {
        CFG_COMP_ENABLE = 3'd0,
        CFG_OPEN_RE     = 3'd1,
        CFG_OPEN_IM     = 3'd2,
        CFG_SHORT_RE    = 3'd3,
        CFG_SHORT_IM    = 3'd4,
        CFG_MODEL_SEL   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        BK_IDLE, BK_CMUL, BK_CDIV, BK_NMUL, BK_PDIV, BK_RMUL, BK_RDIV, BK_QDIV, BK_DONE
    } t_bk_state;

    localparam logic [1:0] MODEL_AUTO     = 2'd0;
    localparam logic [1:0] MODEL_SERIES   = 2'd1;
    localparam logic [1:0] MODEL_PARALLEL = 2'd2;

    localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;
    localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;
    localparam logic [62:0]  R_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]  K_REACT  = 64'd159154943091895336;
    localparam logic [63:0]  TAN5_Q32 = 64'd375760949;
    localparam logic [63:0]  GIGA     = 64'd1000000000;
    localparam logic [127:0] LIMIT_SQ = 128'd1000000000000;

    localparam logic [6:0] QB_S40 = 7'd40;
    localparam logic [6:0] QB_Q48 = 7'd48;
    localparam logic [6:0] QB_CAP = 7'd64;
    localparam logic [6:0] QB_IND = 7'd63;

    function automatic logic [127:0] mag128(input logic signed [127:0] v);
        return v[127] ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [95:0] mag96(input logic signed [127:0] v);
        logic [127:0] m;
        m = mag128(v);
        return m[95:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [39:0] mag40(input logic signed [39:0] v);
        return v[39] ? 40'(~v + 40'd1) : 40'(v);
    endfunction

    // quotient magnitude with sign to saturated 40 bit value
    function automatic t_sat40 sat40(input logic [63:0] q, input logic ovf, input logic neg);
        t_sat40 s;
        s.err = 1'b0;
        if (neg) begin
            if (ovf || q > 64'h0000_0080_0000_0000) begin
                s.val = S40_MIN;
                s.err = 1'b1;
            end else begin
                s.val = 40'(-q[39:0]);
            end
        end else begin
            if (ovf || q > 64'h0000_007F_FFFF_FFFF) begin
                s.val = S40_MAX;
                s.err = 1'b1;
            end else begin
                s.val = q[39:0];
            end
        end
        return s;
    endfunction

endpackage

FILE: hdl/izc_fifo.sv
// izc_fifo: small register queue of fixed word width
// no package dependency

module izc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr & ~o_full;
    assign rd_en   = i_rd & ~o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: hdl/izc_front.sv
// izc_front: takes measured words, forms the lead differences, queues them for the back end
// depends on izc_pkg and izc_fifo

module izc_front
    import izc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  t_in_item           i_item,
    input  logic               i_comp_enable,
    input  logic signed [39:0] i_open_re,
    input  logic signed [39:0] i_open_im,
    input  logic signed [39:0] i_short_re,
    input  logic signed [39:0] i_short_im,
    output t_task              o_task,
    output logic               o_task_empty,
    input  logic               i_task_pop
);
    t_task                   cls;
    logic [$bits(t_task)-1:0] q_rdata;

    always_comb begin
        cls.z_re = i_item.z_re;
        cls.z_im = i_item.z_im;
        cls.freq = i_item.test_freq;
        cls.comp = i_comp_enable;
        cls.ar   = {i_item.z_re[39], i_item.z_re} - {i_short_re[39], i_short_re};
        cls.ai   = {i_item.z_im[39], i_item.z_im} - {i_short_im[39], i_short_im};
        cls.dr   = {i_open_re[39], i_open_re} - {i_item.z_re[39], i_item.z_re};
        cls.di   = {i_open_im[39], i_open_im} - {i_item.z_im[39], i_item.z_im};
    end

    izc_fifo #(
        .WIDTH($bits(t_task)),
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_push),
        .i_wdata(cls),
        .o_full (o_full),
        .i_rd   (i_task_pop),
        .o_rdata(q_rdata),
        .o_empty(o_task_empty)
    );

    assign o_task = t_task'(q_rdata);

endmodule

FILE: hdl/izc_mul.sv
// izc_mul: 96 x 64 bit magnitude multiplier, one 32 x 32 partial product per cycle
// depends on izc_pkg

module izc_mul
    import izc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    localparam logic [2:0] NPP = 3'd6;

    logic                r_busy, r_done, r_neg;
    logic [2:0]          r_k;
    logic [95:0]         r_a;
    logic [63:0]         r_b;
    logic [159:0]        r_acc;
    logic signed [127:0] r_prod;

    logic [31:0]  a_sel, b_sel;
    logic [63:0]  pp;
    logic [2:0]   sh;
    logic [159:0] pp_sh;

    always_comb begin
        case (r_k[2:1])
            2'd0:    a_sel = r_a[31:0];
            2'd1:    a_sel = r_a[63:32];
            2'd2:    a_sel = r_a[95:64];
            default: a_sel = '0;
        endcase
        b_sel = r_k[0] ? r_b[63:32] : r_b[31:0];
        pp    = a_sel * b_sel;
        sh    = {1'b0, r_k[2:1]} + {2'b0, r_k[0]};
        pp_sh = {96'b0, pp} << {sh, 5'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_acc  <= '0;
                r_a    <= i_req.a_mag;
                r_b    <= i_req.b_mag;
                r_neg  <= i_req.neg;
            end else if (r_busy) begin
                if (r_k == NPP) begin
                    r_prod <= r_neg ? 128'(-r_acc[127:0]) : r_acc[127:0];
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc <= r_acc + pp_sh;
                    r_k   <= r_k + 3'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

FILE: hdl/izc_div.sv
// izc_div: restoring divider, one quotient bit per cycle, overflow check up front
// depends on izc_pkg

module izc_div
    import izc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic         r_busy, r_chk, r_done, r_ovf;
    logic [6:0]   r_cnt;
    logic [127:0] r_rem;
    logic [147:0] r_ds;
    logic [63:0]  r_q;
    logic         ge;

    assign ge = ({20'b0, r_rem} >= r_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
                r_rem  <= i_req.num;
                r_ds   <= {64'b0, i_req.den} << i_req.qbits;
                r_cnt  <= i_req.qbits;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                if (r_chk) begin
                    // quotient does not fit in the requested bits
                    r_chk <= 1'b0;
                    if (ge) begin
                        r_ovf  <= 1'b1;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_ds <= r_ds >> 1;
                    end
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - r_ds[127:0];
                    end
                    r_q   <= {r_q[62:0], ge};
                    r_ds  <= r_ds >> 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.ovf  = r_ovf;

endmodule

FILE: hdl/izc_back.sv
// izc_back: sequencer that compensates, picks the model and forms reactance and quality
// depends on izc_pkg, izc_mul and izc_div

module izc_back
    import izc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_task              i_task,
    input  logic               i_task_empty,
    output logic               o_task_pop,
    input  logic signed [39:0] i_open_re,
    input  logic signed [39:0] i_open_im,
    input  logic [1:0]         i_model_sel,
    output t_out_item          o_res,
    output logic               o_res_wr,
    input  logic               i_res_full
);
    t_bk_state r_state, n_state;
    logic      r_busy, n_busy;
    logic [3:0] r_idx, n_idx;

    logic signed [39:0]  r_zr, n_zr, r_zi, n_zi, r_mr, n_mr, r_mi, n_mi;
    logic [19:0]         r_f, n_f;
    logic signed [40:0]  r_ar, n_ar, r_ai, n_ai, r_dr, n_dr, r_di, n_di;
    logic signed [127:0] r_t, n_t, r_pr, n_pr, r_pi, n_pi, r_nr, n_nr, r_ni, n_ni;
    logic [83:0]         r_den, n_den, r_dv, n_dv;
    logic [127:0]        r_nrm, n_nrm;
    logic                r_ind, n_ind, r_par, n_par, r_err, n_err;
    logic [62:0]         r_react, n_react;
    logic signed [47:0]  r_q, n_q;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic signed [127:0] ar128, ai128, dr128, di128, zr128, zi128, mi128, f128;
    logic signed [63:0]  ore64, oim64, dr64, di64, f64;

    assign ar128 = {{87{r_ar[40]}}, r_ar};
    assign ai128 = {{87{r_ai[40]}}, r_ai};
    assign dr128 = {{87{r_dr[40]}}, r_dr};
    assign di128 = {{87{r_di[40]}}, r_di};
    assign zr128 = {{88{r_zr[39]}}, r_zr};
    assign zi128 = {{88{r_zi[39]}}, r_zi};
    assign mi128 = {{88{r_mi[39]}}, r_mi};
    assign f128  = {108'b0, r_f};
    assign ore64 = {{24{i_open_re[39]}}, i_open_re};
    assign oim64 = {{24{i_open_im[39]}}, i_open_im};
    assign dr64  = {{23{r_dr[40]}}, r_dr};
    assign di64  = {{23{r_di[40]}}, r_di};
    assign f64   = {44'b0, r_f};

    izc_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    izc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        logic signed [127:0] ma, sum;
        logic signed [63:0]  mb;
        logic                msgn;
        logic signed [127:0] cnum;
        logic signed [39:0]  pd;
        t_sat40              sc, sp;
        logic [127:0]        rhs;
        logic                par_auto;

        n_state = r_state; n_busy = r_busy; n_idx = r_idx;
        n_zr = r_zr; n_zi = r_zi; n_mr = r_mr; n_mi = r_mi; n_f = r_f;
        n_ar = r_ar; n_ai = r_ai; n_dr = r_dr; n_di = r_di;
        n_t = r_t; n_pr = r_pr; n_pi = r_pi; n_nr = r_nr; n_ni = r_ni;
        n_den = r_den; n_dv = r_dv; n_nrm = r_nrm;
        n_ind = r_ind; n_par = r_par; n_err = r_err; n_react = r_react; n_q = r_q;
        mul_req = '0; div_req = '0;
        o_task_pop = 1'b0; o_res_wr = 1'b0;
        ma = '0; mb = '0; msgn = 1'b0; sum = '0;

        cnum = r_idx[0] ? r_ni : r_nr;
        pd   = r_idx[0] ? r_zi : r_zr;
        sc   = sat40(div_rsp.quo, div_rsp.ovf, cnum[127]);
        sp   = sat40(div_rsp.quo, div_rsp.ovf, pd[39]);
        rhs  = r_zr[39] ? '0 : {56'b0, r_zr, 32'b0};
        par_auto = ((r_zr > 40'sd0) && (128'(mul_rsp.prod) < rhs)) || (r_nrm >= LIMIT_SQ);

        unique case (r_state)
            BK_IDLE: begin
                if (!i_task_empty) begin
                    o_task_pop = 1'b1;
                    n_zr = i_task.z_re; n_zi = i_task.z_im; n_f = i_task.freq;
                    n_ar = i_task.ar; n_ai = i_task.ai; n_dr = i_task.dr; n_di = i_task.di;
                    n_err = 1'b0; n_idx = '0; n_busy = 1'b0;
                    n_state = i_task.comp ? BK_CMUL : BK_NMUL;
                end
            end
            BK_CMUL: begin
                msgn = 1'b1;
                case (r_idx) inside
                    4'd0, 4'd2:       ma = ar128;
                    4'd1, 4'd3:       ma = ai128;
                    4'd4, 4'd7:       ma = r_pr;
                    4'd5, 4'd6:       ma = r_pi;
                    4'd8:             ma = dr128;
                    default:          ma = di128;
                endcase
                case (r_idx) inside
                    4'd0, 4'd3:       mb = ore64;
                    4'd1, 4'd2:       mb = oim64;
                    4'd4, 4'd6, 4'd8: mb = dr64;
                    default:          mb = di64;
                endcase
                if (!r_busy) begin
                    mul_req.start = 1'b1;
                    n_busy = 1'b1;
                end else if (mul_rsp.done) begin
                    n_busy = 1'b0;
                    case (r_idx) inside
                        4'd1:    n_pr = r_t - mul_rsp.prod;
                        4'd3:    n_pi = r_t + mul_rsp.prod;
                        4'd5:    n_nr = r_t + mul_rsp.prod;
                        4'd7:    n_ni = r_t - mul_rsp.prod;
                        4'd9: begin
                            sum   = r_t + mul_rsp.prod;
                            n_den = sum[83:0];
                        end
                        default: n_t = mul_rsp.prod;
                    endcase
                    if (r_idx == 4'd9) begin
                        n_idx = '0;
                        n_state = BK_CDIV;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            BK_CDIV: begin
                if (!r_busy) begin
                    if (r_den == '0) begin
                        // z sits on the open-lead value
                        n_err = 1'b1;
                        if (r_idx[0]) n_zi = cnum[127] ? S40_MIN : S40_MAX;
                        else          n_zr = cnum[127] ? S40_MIN : S40_MAX;
                        n_idx = r_idx[0] ? 4'd0 : 4'd1;
                        if (r_idx[0]) n_state = BK_NMUL;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = mag128(cnum);
                        div_req.den   = r_den;
                        div_req.qbits = QB_S40;
                        n_busy = 1'b1;
                    end
                end else if (div_rsp.done) begin
                    n_busy = 1'b0;
                    n_err  = r_err | sc.err;
                    if (r_idx[0]) n_zi = sc.val;
                    else          n_zr = sc.val;
                    n_idx = r_idx[0] ? 4'd0 : 4'd1;
                    if (r_idx[0]) n_state = BK_NMUL;
                end
            end
            BK_NMUL: begin
                case (r_idx)
                    4'd0:    begin ma = zr128; mb = zr128[63:0]; end
                    4'd1:    begin ma = zi128; mb = zi128[63:0]; end
                    default: begin ma = zi128; mb = TAN5_Q32; end
                endcase
                if (!r_busy) begin
                    mul_req.start = 1'b1;
                    n_busy = 1'b1;
                end else if (mul_rsp.done) begin
                    n_busy = 1'b0;
                    case (r_idx)
                        4'd0:    n_t = mul_rsp.prod;
                        4'd1:    n_nrm = 128'(r_t + mul_rsp.prod);
                        default: ;
                    endcase
                    if (r_idx == 4'd2) begin
                        n_ind = ~r_zi[39];
                        case (i_model_sel)
                            MODEL_SERIES:   n_par = 1'b0;
                            MODEL_PARALLEL: n_par = 1'b1;
                            default:        n_par = par_auto;
                        endcase
                        n_idx = '0;
                        if (n_par) begin
                            n_state = BK_PDIV;
                        end else begin
                            n_mr = r_zr;
                            n_mi = r_zi;
                            n_state = BK_RMUL;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            BK_PDIV: begin
                if (!r_busy) begin
                    if (pd == 40'sd0) begin
                        n_err = 1'b1;
                        if (r_idx[0]) n_mi = S40_MAX;
                        else          n_mr = S40_MAX;
                        n_idx = r_idx[0] ? 4'd0 : 4'd1;
                        if (r_idx[0]) n_state = BK_RMUL;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = r_nrm;
                        div_req.den   = {44'b0, mag40(pd)};
                        div_req.qbits = QB_S40;
                        n_busy = 1'b1;
                    end
                end else if (div_rsp.done) begin
                    n_busy = 1'b0;
                    n_err  = r_err | sp.err;
                    if (r_idx[0]) n_mi = sp.val;
                    else          n_mr = sp.val;
                    n_idx = r_idx[0] ? 4'd0 : 4'd1;
                    if (r_idx[0]) n_state = BK_RMUL;
                end
            end
            BK_RMUL: begin
                if (!r_ind)              begin ma = mi128; mb = f64;     end
                else if (r_idx == 4'd0)  begin ma = mi128; mb = K_REACT; end
                else                     begin ma = f128;  mb = GIGA;    end
                if (!r_busy) begin
                    if (r_ind && r_idx == 4'd0 && r_f == '0) begin
                        n_err = 1'b1;
                        n_react = R_MAX;
                        n_state = BK_QDIV;
                    end else if (r_ind && r_idx == 4'd0 && r_mi <= 40'sd0) begin
                        n_react = '0;
                        n_state = BK_QDIV;
                    end else begin
                        mul_req.start = 1'b1;
                        n_busy = 1'b1;
                    end
                end else if (mul_rsp.done) begin
                    n_busy = 1'b0;
                    if (r_ind && r_idx == 4'd0) begin
                        n_t = mul_rsp.prod;
                        n_idx = 4'd1;
                    end else begin
                        n_dv = mul_rsp.prod[83:0];
                        n_idx = '0;
                        n_state = BK_RDIV;
                    end
                end
            end
            BK_RDIV: begin
                if (!r_busy) begin
                    if (r_dv == '0) begin
                        n_err = 1'b1;
                        n_react = R_MAX;
                        n_state = BK_QDIV;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = r_ind ? 128'(r_t) : {64'b0, K_REACT};
                        div_req.den   = r_dv;
                        div_req.qbits = r_ind ? QB_IND : QB_CAP;
                        n_busy = 1'b1;
                    end
                end else if (div_rsp.done) begin
                    n_busy = 1'b0;
                    if (div_rsp.ovf) begin
                        n_err = 1'b1;
                        n_react = R_MAX;
                    end else begin
                        n_react = div_rsp.quo[62:0];
                    end
                    n_state = BK_QDIV;
                end
            end
            BK_QDIV: begin
                if (!r_busy) begin
                    if (r_zr == 40'sd0) begin
                        n_err = 1'b1;
                        n_q = Q48_MAX;
                        n_state = BK_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = {72'b0, mag40(r_zi), 16'b0};
                        div_req.den   = {44'b0, mag40(r_zr)};
                        div_req.qbits = QB_Q48;
                        n_busy = 1'b1;
                    end
                end else if (div_rsp.done) begin
                    n_busy = 1'b0;
                    if (r_zr[39]) begin
                        if (div_rsp.ovf || div_rsp.quo > 64'h0000_8000_0000_0000) begin
                            n_err = 1'b1;
                            n_q = Q48_MIN;
                        end else begin
                            n_q = 48'(-div_rsp.quo[47:0]);
                        end
                    end else begin
                        if (div_rsp.ovf || div_rsp.quo > 64'h0000_7FFF_FFFF_FFFF) begin
                            n_err = 1'b1;
                            n_q = Q48_MAX;
                        end else begin
                            n_q = div_rsp.quo[47:0];
                        end
                    end
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!i_res_full) begin
                    o_res_wr = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase

        mul_req.a_mag = mag96(ma);
        mul_req.b_mag = mag64(mb);
        mul_req.neg   = msgn & (ma[127] ^ mb[63]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_zr <= n_zr; r_zi <= n_zi; r_mr <= n_mr; r_mi <= n_mi; r_f <= n_f;
        r_ar <= n_ar; r_ai <= n_ai; r_dr <= n_dr; r_di <= n_di;
        r_t <= n_t; r_pr <= n_pr; r_pi <= n_pi; r_nr <= n_nr; r_ni <= n_ni;
        r_den <= n_den; r_dv <= n_dv; r_nrm <= n_nrm;
        r_ind <= n_ind; r_par <= n_par; r_err <= n_err; r_react <= n_react; r_q <= n_q;
    end

    assign o_res.is_inductive   = r_ind;
    assign o_res.is_parallel    = r_par;
    assign o_res.model_re       = r_mr;
    assign o_res.model_im       = r_mi;
    assign o_res.reactive_value = r_react;
    assign o_res.quality        = r_q;
    assign o_res.math_error     = r_err;

endmodule

FILE: hdl/lcr_impedance_to_component_unit.sv
// lcr_impedance_to_component_unit: top level, configuration registers, front, back, result queue
// depends on izc_pkg, izc_fifo, izc_front and izc_back
//
//  channel   direction  handshake                    word
//  input     in         push / full                  i_item   (t_in_item)
//  result    out        empty / pop                  o_result (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// the time one item takes, longer with compensation than without, is set by the
// shared divider (one quotient bit a cycle) and multiplier
// reset is synchronous, active low, and clears the queues, the sequencer and the configuration registers
// the input queue keeps taking words while the back end works; a full result queue stalls
// the back end only, so neither side waits on the other while the queues have room

module lcr_impedance_to_component_unit
    import izc_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    // result channel
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    // configuration registers
    logic               r_comp_enable;
    logic signed [39:0] r_open_re, r_open_im, r_short_re, r_short_im;
    logic [1:0]         r_model_sel;

    t_task     task_w;
    logic      task_empty, task_pop;
    t_out_item res_w;
    logic      res_wr, res_full;
    logic [$bits(t_out_item)-1:0] res_rdata;

    // writes are always taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_enable <= 1'b0;
            r_open_re     <= '0;
            r_open_im     <= '0;
            r_short_re    <= '0;
            r_short_im    <= '0;
            r_model_sel   <= MODEL_AUTO;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COMP_ENABLE: r_comp_enable <= i_cfg_data[0];
                CFG_OPEN_RE:     r_open_re     <= i_cfg_data;
                CFG_OPEN_IM:     r_open_im     <= i_cfg_data;
                CFG_SHORT_RE:    r_short_re    <= i_cfg_data;
                CFG_SHORT_IM:    r_short_im    <= i_cfg_data;
                CFG_MODEL_SEL:   r_model_sel   <= i_cfg_data[1:0];
                default:         ;  // indexes past the list are dropped
            endcase
        end
    end

    // front: lead differences formed on entry, then queued
    izc_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_item),
        .i_comp_enable(r_comp_enable),
        .i_open_re    (r_open_re),
        .i_open_im    (r_open_im),
        .i_short_re   (r_short_re),
        .i_short_im   (r_short_im),
        .o_task       (task_w),
        .o_task_empty (task_empty),
        .i_task_pop   (task_pop)
    );

    // back: compensation, model choice, reactance and quality
    izc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (task_w),
        .i_task_empty(task_empty),
        .o_task_pop  (task_pop),
        .i_open_re   (r_open_re),
        .i_open_im   (r_open_im),
        .i_model_sel (r_model_sel),
        .o_res       (res_w),
        .o_res_wr    (res_wr),
        .i_res_full  (res_full)
    );

    // result queue toward the consumer
    izc_fifo #(
        .WIDTH($bits(t_out_item)),
        .DEPTH(RESULT_DEPTH)
    ) u_result_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (res_wr),
        .i_wdata(res_w),
        .o_full (res_full),
        .i_rd   (pop),
        .o_rdata(res_rdata),
        .o_empty(empty)
    );

    assign o_result = t_out_item'(res_rdata);

endmodule

FILE: tb/sv/lcr_impedance_to_component_unit_test.sv
// lcr_impedance_to_component_unit_test: self-checking bench for the impedance-to-component unit
// depends on izc_pkg and lcr_impedance_to_component_unit; exact integer predictor, queue driven
`timescale 1ns / 1ps

module lcr_impedance_to_component_unit_test;
    import izc_pkg::*;

    localparam logic signed [255:0] W_S40MAX = 256'sh7F_FFFF_FFFF;
    localparam logic signed [255:0] W_S40MIN = -256'sh80_0000_0000;
    localparam logic signed [255:0] W_Q48MAX = 256'sh7FFF_FFFF_FFFF;
    localparam logic signed [255:0] W_RMAX   = 256'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [255:0] W_KREACT = 256'sd159154943091895336;
    localparam logic signed [255:0] W_TAN5   = 256'sd375760949;
    localparam logic signed [255:0] W_LIMSQ  = 256'sd1000000000000;
    localparam logic signed [255:0] W_GIGA   = 256'sd1000000000;
    localparam int ITEMS_PER_PHASE = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [39:0] i_cfg_data = '0;

    lcr_impedance_to_component_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the configuration registers, updated at each write handshake
    logic               sh_comp = 1'b0;
    logic signed [39:0] sh_open_re = '0, sh_open_im = '0, sh_short_re = '0, sh_short_im = '0;
    logic [1:0]         sh_model = MODEL_AUTO;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;

    function automatic logic signed [255:0] mag256(input logic signed [255:0] v);
        return v < 0 ? -v : v;
    endfunction

    // truncating signed divide, saturated to 40 bits; zero divisor saturates by numerator sign
    function automatic logic signed [255:0] div_sat40(input logic signed [255:0] n,
                                                      input logic signed [255:0] d,
                                                      inout logic err);
        logic signed [255:0] q;
        logic neg;
        if (d == 0) begin
            err = 1'b1;
            return n < 0 ? W_S40MIN : W_S40MAX;
        end
        neg = (n < 0) != (d < 0);
        q = mag256(n) / mag256(d);
        if (neg) begin
            if (q > -W_S40MIN) begin
                err = 1'b1;
                return W_S40MIN;
            end
            return -q;
        end
        if (q > W_S40MAX) begin
            err = 1'b1;
            return W_S40MAX;
        end
        return q;
    endfunction

    function automatic t_out_item predict_component(input t_in_item it);
        logic signed [255:0] zr, zi, ar, ai, dr, di, pr, pi, nr, ni, den;
        logic signed [255:0] ore, oim, sre, sim, nrm, lhs, rhs, mr, mi, f, rv, qm, qv;
        logic err, ind, par;
        t_out_item o;
        err = 1'b0;
        zr = it.z_re;
        zi = it.z_im;
        f = {236'd0, it.test_freq};
        ore = sh_open_re;
        oim = sh_open_im;
        sre = sh_short_re;
        sim = sh_short_im;
        // lead compensation (Z - Zs) * Zo / (Zo - Z)
        if (sh_comp) begin
            ar = zr - sre;
            ai = zi - sim;
            dr = ore - zr;
            di = oim - zi;
            pr = ar * ore - ai * oim;
            pi = ar * oim + ai * ore;
            nr = pr * dr + pi * di;
            ni = pi * dr - pr * di;
            den = dr * dr + di * di;
            zr = div_sat40(nr, den, err);
            zi = div_sat40(ni, den, err);
        end
        ind = zi >= 0;
        nrm = zr * zr + zi * zi;
        case (sh_model)
            MODEL_SERIES:   par = 1'b0;
            MODEL_PARALLEL: par = 1'b1;
            default: begin
                // phase within five degrees goes parallel, else by magnitude
                lhs = mag256(zi) * W_TAN5;
                rhs = zr > 0 ? zr * 256'sd4294967296 : 256'sd0;
                if (zr > 0 && lhs < rhs) par = 1'b1;
                else par = !(nrm < W_LIMSQ);
            end
        endcase
        if (par) begin
            mr = div_sat40(nrm, zr, err);
            mi = div_sat40(nrm, zi, err);
        end else begin
            mr = zr;
            mi = zi;
        end
        // capacitance or inductance from the model reactance
        if (!ind) begin
            den = f * mag256(mi);
            if (den == 0) begin
                err = 1'b1;
                rv = W_RMAX;
            end else begin
                rv = W_KREACT / den;
            end
        end else if (f == 0) begin
            err = 1'b1;
            rv = W_RMAX;
        end else if (mi <= 0) begin
            rv = 0;
        end else begin
            rv = (mi * W_KREACT) / (f * W_GIGA);
            if (rv > W_RMAX) begin
                err = 1'b1;
                rv = W_RMAX;
            end
        end
        // quality factor of the compensated impedance
        if (zr == 0) begin
            err = 1'b1;
            qv = W_Q48MAX;
        end else begin
            qm = (mag256(zi) * 256'sd65536) / mag256(zr);
            if (zr < 0) begin
                if (qm > W_Q48MAX + 1) begin
                    err = 1'b1;
                    qv = -W_Q48MAX - 1;
                end else begin
                    qv = -qm;
                end
            end else if (qm > W_Q48MAX) begin
                err = 1'b1;
                qv = W_Q48MAX;
            end else begin
                qv = qm;
            end
        end
        o.is_inductive   = ind;
        o.is_parallel    = par;
        o.model_re       = mr[39:0];
        o.model_im       = mi[39:0];
        o.reactive_value = rv[62:0];
        o.quality        = qv[47:0];
        o.math_error     = err;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // input side: words come from pending_items, holding while full
    always @(posedge i_clk) begin : drive_items
        bit go;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_results.push_back(predict_component(i_item));
                void'(pending_items.pop_front());
            end
            go = pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (push && full) begin
                push <= 1'b1;
            end else if (go) begin
                push <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side: checks each popped word against the oldest prediction
    always @(posedge i_clk) begin : watch_results
        static int hold_left = 0;
        static int holds_done = 0;
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.is_inductive !== want.is_inductive)
                        report_mismatch("is_inductive", o_result.is_inductive, want.is_inductive);
                    if (o_result.is_parallel !== want.is_parallel)
                        report_mismatch("is_parallel", o_result.is_parallel, want.is_parallel);
                    if (o_result.model_re !== want.model_re)
                        report_mismatch("model_re", o_result.model_re, want.model_re);
                    if (o_result.model_im !== want.model_im)
                        report_mismatch("model_im", o_result.model_im, want.model_im);
                    if (o_result.reactive_value !== want.reactive_value)
                        report_mismatch("reactive_value", o_result.reactive_value,
                                        want.reactive_value);
                    if (o_result.quality !== want.quality)
                        report_mismatch("quality", o_result.quality, want.quality);
                    if (o_result.math_error !== want.math_error)
                        report_mismatch("math_error", o_result.math_error, want.math_error);
                end
            end
            // long hold-off so the queues fill and full rises
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left = 3000;
            end
            if (hold_left > 0) hold_left--;
            pop <= hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [39:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMP_ENABLE: sh_comp = data[0];
            CFG_OPEN_RE:     sh_open_re = data;
            CFG_OPEN_IM:     sh_open_im = data;
            CFG_SHORT_RE:    sh_short_re = data;
            CFG_SHORT_IM:    sh_short_im = data;
            CFG_MODEL_SEL:   sh_model = data[1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rand_z();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return 40'($signed(r[10:0]));
            1: return 40'($signed(r[20:0]));
            2: return r[39:0];
            3: case ($urandom_range(0, 4))
                0: return S40_MAX;
                1: return S40_MIN;
                2: return 40'd0;
                3: return 40'd1;
                default: return '1;
            endcase
            4: return 40'($signed(r[30:0]));
            default: return 40'($signed(r[34:0]));
        endcase
    endfunction

    function automatic logic [19:0] rand_freq();
        case ($urandom_range(0, 9))
            0: return 20'($urandom);
            1: return $urandom_range(0, 2) == 0 ? 20'd0 : 20'hFFFFF;
            2: return 20'($urandom_range(1, 100));
            default: return 20'($urandom_range(1, 1000000));
        endcase
    endfunction

    task automatic queue_item(input logic [39:0] re, input logic [39:0] im,
                              input logic [19:0] f);
        t_in_item it;
        it.z_re = re;
        it.z_im = im;
        it.test_freq = f;
        pending_items.push_back(it);
    endtask

    initial begin : stimulus
        logic [39:0] zr, zi, k;
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed words under the reset configuration
        queue_item(S40_MAX, S40_MAX, 20'd1000000);
        queue_item(S40_MIN, S40_MIN, 20'hFFFFF);
        queue_item(S40_MAX, S40_MIN, 20'd1);
        queue_item(S40_MIN, S40_MAX, 20'd1);
        queue_item(40'd0, 40'd0, 20'd1000);        // zero real part and zero reactance
        queue_item(40'd1000, 40'd0, 20'd1000);     // pure resistance
        queue_item(40'd0, 40'd5000, 20'd1000);     // pure reactance
        queue_item(40'd0, -40'sd5000, 20'd1000);
        queue_item(40'd5000, 40'd5000, 20'd0);     // zero frequency, inductive
        queue_item(40'd5000, -40'sd5000, 20'd0);   // zero frequency, capacitive
        queue_item(40'd100000, 40'd8740, 20'd100); // just under five degrees
        queue_item(40'd100000, 40'd8750, 20'd100); // just over five degrees
        queue_item(40'd999, 40'd999, 20'd50);      // small series
        queue_item(40'd2000000000, 40'd3, 20'd50); // large, parallel
        queue_item(-40'sd1000, 40'd20, 20'd10);    // negative real part
        queue_item(40'd1, S40_MAX, 20'd1);         // quality saturation
        queue_item(-40'sd1, S40_MAX, 20'd1);
        queue_item(40'd1, -40'sd1, 20'hFFFFF);
        queue_item(40'd1000000, 40'd1000000, 20'd1);
        wait_drained();

        // forced models and compensation, including Z equal to Zo
        cfg_write(CFG_MODEL_SEL, 40'(MODEL_PARALLEL));
        queue_item(40'd0, 40'd700, 20'd1000);      // parallel with zero real part
        queue_item(40'd700, 40'd0, 20'd1000);      // parallel with zero reactance
        wait_drained();
        cfg_write(CFG_COMP_ENABLE, 40'd1);
        cfg_write(CFG_OPEN_RE, 40'd5000000);
        cfg_write(CFG_OPEN_IM, -40'sd90000000);
        cfg_write(CFG_SHORT_RE, 40'd20);
        cfg_write(CFG_SHORT_IM, 40'd300);
        cfg_write(CFG_MODEL_SEL, 40'(MODEL_SERIES));
        queue_item(40'd5000000, -40'sd90000000, 20'd1000); // compensation divisor zero
        queue_item(40'd20, 40'd300, 20'd1000);             // equals the short
        wait_drained();

        for (p = 0; p < 8; p++) begin
            // configuration for this phase; extremes in a couple of them
            cfg_write(CFG_COMP_ENABLE, 40'(p % 2));
            case (p)
                3: begin
                    cfg_write(CFG_OPEN_RE, S40_MAX);
                    cfg_write(CFG_OPEN_IM, S40_MIN);
                    cfg_write(CFG_SHORT_RE, S40_MIN);
                    cfg_write(CFG_SHORT_IM, S40_MAX);
                end
                5: begin
                    cfg_write(CFG_OPEN_RE, 40'd0);
                    cfg_write(CFG_OPEN_IM, 40'd0);
                    cfg_write(CFG_SHORT_RE, 40'd0);
                    cfg_write(CFG_SHORT_IM, 40'd0);
                end
                default: begin
                    cfg_write(CFG_OPEN_RE, rand_z());
                    cfg_write(CFG_OPEN_IM, 40'($signed(40'({$urandom, $urandom}))) >>> 2);
                    cfg_write(CFG_SHORT_RE, 40'($signed(12'($urandom))));
                    cfg_write(CFG_SHORT_IM, rand_z());
                end
            endcase
            cfg_write(CFG_MODEL_SEL, 40'(p % 4));  // includes the unused selector value
            case (p % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 57; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 57; end
                default: begin send_idle_pct <= 36; recv_stall_pct <= 36; end
            endcase
            if (p == 4) hold_requests <= hold_requests + 1;
            repeat (ITEMS_PER_PHASE) begin
                zr = rand_z();
                zi = rand_z();
                case ($urandom_range(0, 9))
                    0: begin
                        // phase near the five degree border
                        zr = 40'($urandom_range(1000, 1 << 30));
                        k = 40'($urandom_range(8, 16));
                        zi = $urandom_range(0, 1) ? 40'(zr / k) : 40'(-(zr / k));
                    end
                    1: begin
                        zr = sh_open_re;
                        zi = sh_open_im;
                    end
                    default: ;
                endcase
                queue_item(zr, zi, rand_freq());
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule
